>>> src/airw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// airw_pkg
// Shared types and codes for the algebraic identity rewriter.
// ----------------------------------------------------------------------------
package airw_pkg;

  localparam int NUM_VREGS_DEF = 1024;
  localparam int EPOCH_W       = 8;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_IMM  = 2'd1;
  localparam logic [1:0] K_REG  = 2'd2;

  localparam logic [4:0] F_ADD  = 5'd1;
  localparam logic [4:0] F_SUB  = 5'd2;
  localparam logic [4:0] F_MUL  = 5'd3;
  localparam logic [4:0] F_DIV  = 5'd4;
  localparam logic [4:0] F_MOD  = 5'd5;
  localparam logic [4:0] F_AND  = 5'd6;
  localparam logic [4:0] F_OR   = 5'd7;
  localparam logic [4:0] F_XOR  = 5'd8;
  localparam logic [4:0] F_SHL  = 5'd9;
  localparam logic [4:0] F_SHR  = 5'd10;
  localparam logic [4:0] F_SAR  = 5'd11;
  localparam logic [4:0] F_SDIVP = 5'd12;
  localparam logic [4:0] F_UDIVP = 5'd13;
  localparam logic [4:0] F_SMODP = 5'd14;
  localparam logic [4:0] F_UMODP = 5'd15;
  localparam logic [4:0] F_MOV  = 5'd16;
  localparam logic [4:0] F_MOVI = 5'd17;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_MOVA = 2'd1,
    ACT_MOVB = 2'd2,
    ACT_ZERO = 2'd3
  } act_t;

  typedef struct packed {
    logic [4:0]         func;
    logic               narrow_width;
    logic [1:0]         a_kind;
    logic signed [63:0] a_value;
    logic [1:0]         b_kind;
    logic signed [63:0] b_value;
    logic [5:0]         pow2_exponent;
    logic               dest_valid;
    logic [9:0]         dest_reg;
    logic               block_start;
  } req_t;

  typedef struct packed {
    logic               rewritten;
    logic [4:0]         result_func;
    logic [1:0]         result_a_kind;
    logic signed [63:0] result_a_value;
    logic [1:0]         result_b_kind;
    logic signed [63:0] result_b_value;
  } rsp_t;

  typedef struct packed {
    act_t               act;
    logic [4:0]         func;
    logic [1:0]         a_kind;
    logic signed [63:0] a_value;
    logic [1:0]         b_kind;
    logic signed [63:0] b_value;
  } qent_t;

endpackage

>>> src/algebraic_identity_rewriter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// algebraic_identity_rewriter_unit
// Peephole identity rewriter with per-block known-constant tracking.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one instruction per transfer (req_valid / req_stall / req).
//   rsp channel: one rewritten instruction per transfer (rsp_valid /
//   rsp_stall / rsp), in request order.
//   The request enters the lookup stage register at its transfer edge, then
//   a queue slot and the result register, before rsp_valid rises.
//   Throughput: one instruction per cycle while req_stall is low,
//   set by the single lookup/update stage and its one table write port.
//   Reset: a clearing pass walks the constant table; req_stall stays high
//   during it. Block starts bump an 8-bit epoch mark instead of clearing;
//   every 255 block starts the epoch wraps and the same clearing pass runs
//   once the lookup stage has drained.
//   Receiver stall: the result register holds, the two-entry queue fills,
//   then the lookup stage holds and req_stall rises.
// ----------------------------------------------------------------------------
module algebraic_identity_rewriter_unit #(
  parameter int NUM_VREGS = airw_pkg::NUM_VREGS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  airw_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output airw_pkg::rsp_t rsp
);
  import airw_pkg::*;

  // front -> queue
  logic  f_valid, f_stall;
  qent_t f_data;
  // queue -> back
  logic  b_valid, b_stall;
  qent_t b_data;

  airw_front #(.NUM_VREGS(NUM_VREGS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (f_valid),
    .q_stall   (f_stall),
    .q_data    (f_data)
  );

  airw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_stall (f_stall),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_stall (b_stall),
    .rd_data  (b_data)
  );

  airw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_stall   (b_stall),
    .q_data    (b_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> src/airw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// airw_front
// Accepts instructions, looks up the known-constant table and picks a rule.
// ----------------------------------------------------------------------------
module airw_front #(
  parameter int NUM_VREGS = airw_pkg::NUM_VREGS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  airw_pkg::req_t  req,
  output logic            q_valid,
  input  logic            q_stall,
  output airw_pkg::qent_t q_data
);
  import airw_pkg::*;

  localparam int AW = (NUM_VREGS > 1) ? $clog2(NUM_VREGS) : 1;

  typedef struct packed {
    logic               flag;
    logic [EPOCH_W-1:0] epoch;
    logic [63:0]        value;
  } ent_t;

  ent_t mem [NUM_VREGS];

  logic               sweeping;
  logic [AW-1:0]      sweep_idx;
  logic [EPOCH_W-1:0] epoch;
  logic               s1_valid;
  req_t               s1;
  logic [EPOCH_W-1:0] s1_epoch;
  ent_t               rd_a, rd_b;
  logic               lw_valid;
  logic [AW-1:0]      lw_addr;
  ent_t               lw;

  logic               wrap_wait, acc, s1_adv;
  logic [EPOCH_W-1:0] epoch_next;
  ent_t               ea, eb, wd;
  logic               a_rng, b_rng, ac, bc, same, a0, b0, a1, b1;
  logic [63:0]        av, bv;
  act_t               act;
  logic [4:0]         rfunc;
  logic               d_rng, upd;
  logic [AW-1:0]      a_idx, b_idx, d_idx;
  logic [31:0]        d_ext;

  function automatic logic ones(input logic [63:0] v, input logic narrow);
    ones = narrow ? (v[31:0] == 32'hFFFF_FFFF) : (v == 64'hFFFF_FFFF_FFFF_FFFF);
  endfunction

  assign wrap_wait = req_valid && req.block_start && (epoch == {EPOCH_W{1'b1}});
  assign s1_adv    = s1_valid && !q_stall;
  assign req_stall = sweeping || wrap_wait || (s1_valid && q_stall);
  assign acc       = req_valid && !req_stall;
  assign epoch_next = req.block_start ? epoch + 1'b1 : epoch;

  // operand lookup with forwarding from the previous table write
  always_comb begin
    a_idx = s1.a_value[AW-1:0];
    b_idx = s1.b_value[AW-1:0];
    ea = (lw_valid && lw_addr == a_idx) ? lw : rd_a;
    eb = (lw_valid && lw_addr == b_idx) ? lw : rd_b;
    a_rng = (s1.a_kind == K_REG) && (s1.a_value[63:AW] == '0)
            && (32'(a_idx) < NUM_VREGS);
    b_rng = (s1.b_kind == K_REG) && (s1.b_value[63:AW] == '0)
            && (32'(b_idx) < NUM_VREGS);
    ac = (s1.a_kind == K_IMM) || (a_rng && ea.flag && ea.epoch == s1_epoch);
    bc = (s1.b_kind == K_IMM) || (b_rng && eb.flag && eb.epoch == s1_epoch);
    av = (s1.a_kind == K_IMM) ? s1.a_value : ea.value;
    bv = (s1.b_kind == K_IMM) ? s1.b_value : eb.value;
    same = (s1.a_kind == K_REG) && (s1.b_kind == K_REG) && (s1.a_value == s1.b_value);
    a0 = ac && (av == '0);
    b0 = bc && (bv == '0);
    a1 = ac && (av == 64'd1);
    b1 = bc && (bv == 64'd1);
  end

  always_comb begin
    act = ACT_NONE;
    unique case (s1.func)
      F_ADD, F_OR: begin
        if (b0) act = ACT_MOVA;
        else if (a0) act = ACT_MOVB;
      end
      F_SUB: begin
        if (same) act = ACT_ZERO;
        else if (b0) act = ACT_MOVA;
      end
      F_MUL: begin
        if (a0 || b0) act = ACT_ZERO;
        else if (b1) act = ACT_MOVA;
        else if (a1) act = ACT_MOVB;
      end
      F_DIV: if (b1) act = ACT_MOVA;
      F_MOD: if (b1) act = ACT_ZERO;
      F_AND: begin
        if (a0 || b0) act = ACT_ZERO;
        else if (bc && ones(bv, s1.narrow_width)) act = ACT_MOVA;
        else if (ac && ones(av, s1.narrow_width)) act = ACT_MOVB;
      end
      F_XOR: begin
        if (same || (a0 && b0)) act = ACT_ZERO;
        else if (b0) act = ACT_MOVA;
        else if (a0) act = ACT_MOVB;
      end
      F_SHL, F_SHR, F_SAR: if (b0) act = ACT_MOVA;
      F_SDIVP, F_UDIVP: if (s1.pow2_exponent == '0) act = ACT_MOVA;
      F_SMODP, F_UMODP: if (s1.pow2_exponent == '0) act = ACT_ZERO;
      default: act = ACT_NONE;
    endcase
  end

  // table update for the destination
  always_comb begin
    unique case (act)
      ACT_MOVA, ACT_MOVB: rfunc = F_MOV;
      ACT_ZERO:           rfunc = F_MOVI;
      default:            rfunc = s1.func;
    endcase
    d_ext = 32'(s1.dest_reg);
    d_idx = d_ext[AW-1:0];
    d_rng = d_ext < NUM_VREGS;
    upd   = s1_adv && s1.dest_valid && d_rng;
    wd.epoch = s1_epoch;
    if (act == ACT_ZERO) begin
      wd.flag  = 1'b1;
      wd.value = '0;
    end else if (rfunc == F_MOVI) begin
      wd.flag  = 1'b1;
      wd.value = s1.a_value;
    end else if (rfunc == F_MOV) begin
      wd.flag  = (act == ACT_MOVB) ? bc : ac;
      wd.value = (act == ACT_MOVB) ? bv : av;
    end else begin
      wd.flag  = 1'b0;
      wd.value = av;
    end
  end

  always_ff @(posedge clk) begin
    if (sweeping) begin
      mem[sweep_idx] <= '0;
    end else if (upd) begin
      mem[d_idx] <= wd;
    end
    if (acc) begin
      rd_a <= mem[req.a_value[AW-1:0]];
      rd_b <= mem[req.b_value[AW-1:0]];
      s1   <= req;
      s1_epoch <= epoch_next;
    end
    if (upd) begin
      lw_addr <= d_idx;
      lw      <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping  <= 1'b1;
      sweep_idx <= '0;
      epoch     <= '0;
      s1_valid  <= 1'b0;
      lw_valid  <= 1'b0;
    end else begin
      if (sweeping) begin
        sweep_idx <= sweep_idx + 1'b1;
        if (sweep_idx == AW'(NUM_VREGS - 1)) begin
          sweeping <= 1'b0;
          epoch    <= '0;
        end
        lw_valid <= 1'b0;
      end else if (wrap_wait && !s1_valid) begin
        sweeping  <= 1'b1;
        sweep_idx <= '0;
      end else begin
        if (upd) lw_valid <= 1'b1;
      end
      if (acc) begin
        epoch    <= epoch_next;
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  assign q_valid        = s1_valid;
  assign q_data.act     = act;
  assign q_data.func    = s1.func;
  assign q_data.a_kind  = s1.a_kind;
  assign q_data.a_value = s1.a_value;
  assign q_data.b_kind  = s1.b_kind;
  assign q_data.b_value = s1.b_value;

endmodule

>>> src/airw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// airw_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module airw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_stall,
  input  airw_pkg::qent_t wr_data,
  output logic            rd_valid,
  input  logic            rd_stall,
  output airw_pkg::qent_t rd_data
);
  import airw_pkg::*;

  qent_t      slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> src/airw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// airw_back
// Applies the chosen rewrite and holds the result register.
// ----------------------------------------------------------------------------
module airw_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_stall,
  input  airw_pkg::qent_t q_data,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output airw_pkg::rsp_t  rsp
);
  import airw_pkg::*;

  rsp_t nxt;
  logic take;

  assign q_stall = rsp_valid && rsp_stall;
  assign take    = q_valid && !q_stall;

  always_comb begin
    nxt.rewritten      = (q_data.act != ACT_NONE);
    nxt.result_func    = q_data.func;
    nxt.result_a_kind  = q_data.a_kind;
    nxt.result_a_value = q_data.a_value;
    nxt.result_b_kind  = q_data.b_kind;
    nxt.result_b_value = q_data.b_value;
    unique case (q_data.act)
      ACT_MOVA: begin
        nxt.result_func    = F_MOV;
        nxt.result_b_kind  = K_NONE;
        nxt.result_b_value = '0;
      end
      ACT_MOVB: begin
        nxt.result_func    = F_MOV;
        nxt.result_a_kind  = q_data.b_kind;
        nxt.result_a_value = q_data.b_value;
        nxt.result_b_kind  = K_NONE;
        nxt.result_b_value = '0;
      end
      ACT_ZERO: begin
        nxt.result_func    = F_MOVI;
        nxt.result_a_kind  = K_IMM;
        nxt.result_a_value = '0;
        nxt.result_b_kind  = K_NONE;
        nxt.result_b_value = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) rsp <= nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
